[hw/rtl/ssh_pkg.sv]
// shared types and constants of the space-saving top-k heap
package ssh_pkg;

    // default sizes
    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_MAX_REPORT = 64;
    localparam int DEF_KEY_BITS   = 32;

    // fixed field widths
    localparam int FIELD_KEY_W    = 32;
    localparam int COUNT_W        = 32;
    localparam int RANK_W         = 6;
    localparam int RPT_CNT_W      = 7;
    localparam int CAP_CFG_W      = 9;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 32;

    // reset values of the configuration registers
    localparam logic [RPT_CNT_W-1:0] RESET_REPORT_COUNT = 7'd10;
    localparam logic [CAP_CFG_W-1:0] RESET_CAPACITY     = 9'd256;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_REPORT_COUNT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY     = 8'd1;

    // request kinds
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    // one report result
    typedef struct packed {
        logic [RANK_W-1:0]      rank;
        logic [FIELD_KEY_W-1:0] top_key;
        logic                   key_valid;
        logic                   last;
    } result_t;

endpackage

[hw/rtl/ssh_ram.sv]
// single write port, single registered read port entry memory
module ssh_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int W     = 65
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/ssh_core.sv]
// sequencer for key search, heap sifts and report scans over the entry memory
module ssh_core #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [$clog2(CAPACITY+1)-1:0]          eff_capacity,
    input  logic [ssh_pkg::RPT_CNT_W-1:0]          eff_report,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   in_type,
    input  logic [ssh_pkg::FIELD_KEY_W-1:0]        in_key,
    input  logic [ssh_pkg::COUNT_W-1:0]            in_weight,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output ssh_pkg::result_t                       res
);
    import ssh_pkg::*;

    localparam int KW = (KEY_BITS < FIELD_KEY_W) ? KEY_BITS : FIELD_KEY_W;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EW = KW + COUNT_W + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SRCH = 4'd1;
    localparam logic [3:0] S_ROOT = 4'd2;
    localparam logic [3:0] S_DN_A = 4'd3;
    localparam logic [3:0] S_DN_B = 4'd4;
    localparam logic [3:0] S_DN_C = 4'd5;
    localparam logic [3:0] S_DN_E = 4'd6;
    localparam logic [3:0] S_UP_A = 4'd7;
    localparam logic [3:0] S_UP_B = 4'd8;
    localparam logic [3:0] S_SCAN = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    logic [3:0]           state_reg, state_next;
    logic [PW-1:0]        fill_reg, fill_next;
    logic [PW-1:0]        x_reg, x_next;
    logic [KW-1:0]        t_key_reg, t_key_next;
    logic [COUNT_W-1:0]   t_cnt_reg, t_cnt_next;
    logic [PW-1:0]        c_pos_reg, c_pos_next;
    logic [KW-1:0]        c_key_reg, c_key_next;
    logic [COUNT_W-1:0]   c_cnt_reg, c_cnt_next;
    logic                 c_vld_reg, c_vld_next;
    logic [PW:0]          rd_idx_reg, rd_idx_next;
    logic                 pend_reg, pend_next;
    logic [PW-1:0]        pend_idx_reg, pend_idx_next;
    logic [KW-1:0]        key_reg, key_next;
    logic [COUNT_W-1:0]   wgt_reg, wgt_next;
    logic [KW-1:0]        best_key_reg, best_key_next;
    logic [COUNT_W-1:0]   best_cnt_reg, best_cnt_next;
    logic                 best_vld_reg, best_vld_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [RANK_W-1:0]    round_reg, round_next;
    logic [RPT_CNT_W-1:0] n_reg, n_next;

    // memory port signals
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data, rd_data;
    logic [KW-1:0]      rd_key;
    logic [COUNT_W-1:0] rd_cnt;
    logic               rd_vld;
    logic [PW:0]        child;
    logic               is_last;

    assign rd_key = rd_data[KW-1:0];
    assign rd_cnt = rd_data[KW+COUNT_W-1:KW];
    assign rd_vld = rd_data[EW-1];
    assign child  = {x_reg, 1'b0};
    assign is_last = ({1'b0, round_reg} + 7'd1) == n_reg;

    function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] pos);
        logic [PW-1:0] a;
        a = pos - 1'b1;
        return AW'(a);
    endfunction

    ssh_ram #(.DEPTH(CAPACITY), .AW(AW), .W(EW)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res.rank      = round_reg;
    assign res.top_key   = best_vld_reg ? FIELD_KEY_W'(best_key_reg) : '0;
    assign res.key_valid = best_vld_reg;
    assign res.last      = is_last;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        x_next        = x_reg;
        t_key_next    = t_key_reg;
        t_cnt_next    = t_cnt_reg;
        c_pos_next    = c_pos_reg;
        c_key_next    = c_key_reg;
        c_cnt_next    = c_cnt_reg;
        c_vld_next    = c_vld_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        key_next      = key_reg;
        wgt_next      = wgt_reg;
        best_key_next = best_key_reg;
        best_cnt_next = best_cnt_reg;
        best_vld_next = best_vld_reg;
        p_next        = p_reg;
        round_next    = round_reg;
        n_next        = n_reg;
        wr_en   = 1'b0;
        wr_addr = addr_of(x_reg);
        wr_data = {1'b1, t_cnt_reg, t_key_reg};
        rd_en   = 1'b0;
        rd_addr = addr_of(PW'(rd_idx_reg));
        unique case (state_reg)
            S_IDLE: begin
                rd_idx_next   = (PW+1)'(1);
                best_vld_next = 1'b0;
                best_key_next = '0;
                p_next        = PW'(1);
                round_next    = '0;
                key_next      = in_key[KW-1:0];
                wgt_next      = in_weight;
                n_next        = eff_report;
                if (in_valid) begin
                    state_next = (in_type == REQ_REPORT) ? S_SCAN : S_SRCH;
                end
            end
            // linear key search, one read per cycle
            S_SRCH: begin
                if (pend_reg && rd_vld && rd_key == key_reg) begin
                    t_key_next = rd_key;
                    t_cnt_next = rd_cnt + wgt_reg;
                    x_next     = pend_idx_reg;
                    state_next = S_DN_A;
                end else if (rd_idx_reg <= {1'b0, fill_reg}) begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = PW'(rd_idx_reg);
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end else if (fill_reg < eff_capacity) begin
                    fill_next  = fill_reg + 1'b1;
                    x_next     = fill_reg + 1'b1;
                    t_key_next = key_reg;
                    t_cnt_next = wgt_reg;
                    state_next = S_UP_A;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(PW'(1));
                    state_next = S_ROOT;
                end
            end
            // root replacement adds the weight to the old count
            S_ROOT: begin
                t_key_next = key_reg;
                t_cnt_next = rd_cnt + wgt_reg;
                x_next     = PW'(1);
                state_next = S_DN_A;
            end
            // sift down: read first child
            S_DN_A: begin
                if (child > {1'b0, fill_reg}) begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    c_pos_next = PW'(child);
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(PW'(child));
                    state_next = S_DN_B;
                end
            end
            // latch first child, read second if present
            S_DN_B: begin
                c_key_next = rd_key;
                c_cnt_next = rd_cnt;
                c_vld_next = rd_vld;
                if (c_pos_reg < fill_reg) begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(c_pos_reg + 1'b1);
                    state_next = S_DN_C;
                end else begin
                    state_next = S_DN_E;
                end
            end
            // pick the smaller child
            S_DN_C: begin
                if (c_cnt_reg > rd_cnt) begin
                    c_pos_next = c_pos_reg + 1'b1;
                    c_key_next = rd_key;
                    c_cnt_next = rd_cnt;
                    c_vld_next = rd_vld;
                end
                state_next = S_DN_E;
            end
            // place held entry or move child up
            S_DN_E: begin
                wr_en = 1'b1;
                if (t_cnt_reg <= c_cnt_reg) begin
                    state_next = S_IDLE;
                end else begin
                    wr_data    = {c_vld_reg, c_cnt_reg, c_key_reg};
                    x_next     = c_pos_reg;
                    state_next = S_DN_A;
                end
            end
            // sift up: read parent
            S_UP_A: begin
                if ((x_reg >> 1) == '0) begin
                    wr_en      = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = addr_of(x_reg >> 1);
                    state_next = S_UP_B;
                end
            end
            S_UP_B: begin
                wr_en = 1'b1;
                if (rd_cnt <= t_cnt_reg) begin
                    state_next = S_IDLE;
                end else begin
                    wr_data    = rd_data;
                    x_next     = x_reg >> 1;
                    state_next = S_UP_A;
                end
            end
            // report scan for the first strictly greatest count
            S_SCAN: begin
                if (pend_reg && (pend_idx_reg == PW'(1) || rd_cnt > best_cnt_reg)) begin
                    best_key_next = rd_key;
                    best_cnt_next = rd_cnt;
                    best_vld_next = rd_vld;
                    p_next        = pend_idx_reg;
                end
                if (rd_idx_reg <= {1'b0, fill_reg}) begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = PW'(rd_idx_reg);
                    rd_idx_next   = rd_idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = S_EMIT;
                end
            end
            // hand out the result and clear the chosen entry
            S_EMIT: begin
                if (res_ready) begin
                    wr_en         = 1'b1;
                    wr_addr       = addr_of(p_reg);
                    wr_data       = {1'b0, {COUNT_W{1'b0}}, best_key_reg};
                    rd_idx_next   = (PW+1)'(1);
                    best_vld_next = 1'b0;
                    best_key_next = '0;
                    p_next        = PW'(1);
                    round_next    = round_reg + 1'b1;
                    state_next    = is_last ? S_IDLE : S_SCAN;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        t_key_reg    <= t_key_next;
        t_cnt_reg    <= t_cnt_next;
        c_pos_reg    <= c_pos_next;
        c_key_reg    <= c_key_next;
        c_cnt_reg    <= c_cnt_next;
        c_vld_reg    <= c_vld_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        key_reg      <= key_next;
        wgt_reg      <= wgt_next;
        best_key_reg <= best_key_next;
        best_cnt_reg <= best_cnt_next;
        best_vld_reg <= best_vld_next;
        p_reg        <= p_next;
        round_reg    <= round_next;
        n_reg        <= n_next;
    end

endmodule

[hw/rtl/space_saving_topk_heap.sv]
// Space-Saving heavy-hitter counter over a min-heap, top level
//
// s_ channel: one transaction per request. s_tuser = req_type (0 update,
// 1 report); s_tdata = item_key, weight. Updates produce no result.
// m_ channel: a report yields report_count results (1..MAX_REPORT), rank 0
// first, m_tlast on the final one; m_tuser = key_valid.
// cfg channel: index 0 report_count, index 1 capacity_in_use; others ignored.
// s_tready is low while a request is processed. Everything runs through one
// entry memory with one read port: an update reads the filled entries one by one
// until it finds the key, then sifts the new or changed entry through the heap
// level by level; a report scans all filled entries once for each result.
// Results leave through an output register; when the receiver stalls the
// sequencer holds the next result until the register frees up.
// Reset empties the heap (fill level zero) and loads report_count 10 and
// capacity_in_use 256; no clearing pass is needed.
module space_saving_topk_heap #(
    parameter int CAPACITY   = ssh_pkg::DEF_CAPACITY,
    parameter int MAX_REPORT = ssh_pkg::DEF_MAX_REPORT,
    parameter int KEY_BITS   = ssh_pkg::DEF_KEY_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [63:0]                        s_tdata,  // item_key, weight
    input  logic                               s_tuser,  // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,  // rank, top_key, zero pad
    output logic                               m_tuser,  // key_valid
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ssh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ssh_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ssh_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);

    logic [RPT_CNT_W-1:0] rpt_reg, rpt_next;
    logic [CAP_CFG_W-1:0] cap_reg, cap_next;
    logic [PW-1:0]        eff_capacity;
    logic [RPT_CNT_W-1:0] eff_report;
    logic                 res_valid, res_ready;
    result_t              res;
    logic                 out_vld_reg, out_vld_next;
    result_t              out_reg, out_next;

    // configuration writes
    assign cfg_ready = 1'b1;
    always_comb begin
        rpt_next = rpt_reg;
        cap_next = cap_reg;
        if (cfg_valid) begin
            if (cfg_index == REG_REPORT_COUNT) rpt_next = cfg_data[RPT_CNT_W-1:0];
            if (cfg_index == REG_CAPACITY)     cap_next = cfg_data[CAP_CFG_W-1:0];
        end
    end

    // clamp configuration values
    always_comb begin
        if (cap_reg == '0) begin
            eff_capacity = PW'(1);
        end else if (32'(cap_reg) > 32'(CAPACITY)) begin
            eff_capacity = PW'(CAPACITY);
        end else begin
            eff_capacity = PW'(cap_reg);
        end
        if (rpt_reg == '0) begin
            eff_report = RPT_CNT_W'(1);
        end else if (32'(rpt_reg) > 32'(MAX_REPORT)) begin
            eff_report = RPT_CNT_W'(MAX_REPORT);
        end else begin
            eff_report = rpt_reg;
        end
    end

    ssh_core #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .eff_capacity (eff_capacity),
        .eff_report   (eff_report),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_type      (s_tuser),
        .in_key       (s_tdata[31:0]),
        .in_weight    (s_tdata[63:32]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // output register
    assign res_ready = !out_vld_reg || m_tready;
    always_comb begin
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (res_ready) begin
            out_vld_next = res_valid;
            if (res_valid) out_next = res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {2'b00, out_reg.top_key, out_reg.rank};
    assign m_tuser  = out_reg.key_valid;
    assign m_tlast  = out_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpt_reg     <= RESET_REPORT_COUNT;
            cap_reg     <= RESET_CAPACITY;
            out_vld_reg <= 1'b0;
        end else begin
            rpt_reg     <= rpt_next;
            cap_reg     <= cap_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

[bench/space_saving_topk_heap_tb.sv]
// testbench of the space-saving top-k heap: directed and random requests, checked in order
`timescale 1ns / 1ps

module space_saving_topk_heap_tb;
    import ssh_pkg::*;

    localparam int HEAP_DEPTH  = 256;
    localparam int REPORT_MAX  = 64;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int SETTLE      = 400;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [63:0]            s_tdata;   // item_key, weight
    logic                   s_tuser;   // req_type
    logic                   m_tvalid;
    logic                   m_tready;
    logic [39:0]            m_tdata;   // rank, top_key, zero pad
    logic                   m_tuser;   // key_valid
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    space_saving_topk_heap uut (.*);

    // mirror of the heap and registers
    logic [31:0] heap_key [1:HEAP_DEPTH];
    logic [31:0] heap_cnt [1:HEAP_DEPTH];
    bit          heap_val [1:HEAP_DEPTH];
    int          heap_fill;
    logic [6:0]  top_n_reg;
    logic [8:0]  cap_reg;

    result_t     pending_results[$];
    int          error_count;
    int          cycle_count;
    int          rx_hold;
    bit          rx_burst;
    bit          tx_burst;
    logic [31:0] key_pool[12];

    // clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("space_saving_topk_heap verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        error_count++;
    endtask

    function automatic void swap_entries(input int a, input int b);
        logic [31:0] k;
        logic [31:0] c;
        bit v;
        k = heap_key[a]; c = heap_cnt[a]; v = heap_val[a];
        heap_key[a] = heap_key[b]; heap_cnt[a] = heap_cnt[b]; heap_val[a] = heap_val[b];
        heap_key[b] = k; heap_cnt[b] = c; heap_val[b] = v;
    endfunction

    function automatic void heap_rise(input int x);
        while (x > 1 && heap_cnt[x >> 1] > heap_cnt[x]) begin
            swap_entries(x, x >> 1);
            x = x >> 1;
        end
    endfunction

    function automatic void heap_sink(input int x);
        int c;
        c = 2 * x;
        while (c <= heap_fill) begin
            if (c < heap_fill && heap_cnt[c] > heap_cnt[c + 1]) c++;
            if (heap_cnt[x] <= heap_cnt[c]) break;
            swap_entries(x, c);
            x = c;
            c = 2 * x;
        end
    endfunction

    // count update of one key
    function automatic void count_key(input logic [31:0] key, input logic [31:0] w);
        int cap;
        cap = (cap_reg == 0) ? 1 : ((cap_reg > HEAP_DEPTH) ? HEAP_DEPTH : cap_reg);
        for (int i = 1; i <= heap_fill; i++) begin
            if (heap_val[i] && heap_key[i] == key) begin
                heap_cnt[i] = heap_cnt[i] + w;
                heap_sink(i);
                return;
            end
        end
        if (heap_fill < cap) begin
            heap_fill++;
            heap_key[heap_fill] = key;
            heap_cnt[heap_fill] = w;
            heap_val[heap_fill] = 1'b1;
            heap_rise(heap_fill);
        end else begin
            heap_key[1] = key;
            heap_cnt[1] = heap_cnt[1] + w;
            heap_val[1] = 1'b1;
            heap_sink(1);
        end
    endfunction

    // top entries of one report, queued in emission order
    function automatic void rank_top_entries();
        int n;
        int p;
        result_t r;
        n = (top_n_reg == 0) ? 1 : ((top_n_reg > REPORT_MAX) ? REPORT_MAX : top_n_reg);
        for (int t = 0; t < n; t++) begin
            p = 1;
            for (int i = 1; i <= heap_fill; i++)
                if (heap_cnt[p] < heap_cnt[i]) p = i;
            r.rank      = t[RANK_W-1:0];
            r.top_key   = heap_val[p] ? heap_key[p] : 32'd0;
            r.key_valid = heap_val[p];
            r.last      = (t + 1 == n);
            pending_results.push_back(r);
            heap_cnt[p] = 32'd0;
            heap_val[p] = 1'b0;
        end
    endfunction

    // one request transaction
    task automatic send_request(input logic kind, input logic [31:0] key,
                                input logic [31:0] w);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {w, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == REQ_UPDATE) count_key(key, w);
        else rank_top_entries();
    endtask

    // wait for all results and for the last update to finish
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_REPORT_COUNT) top_n_reg = val[6:0];
        else if (idx == REG_CAPACITY) cap_reg = val[8:0];
    endtask

    // result receiver and checker
    initial begin
        int gap;
        result_t want;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold > 0) gap = rx_hold;
            else gap = rx_burst ? 0 : $urandom_range(0, 10);
            rx_hold = 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (pending_results.size() == 0) begin
                $display("unexpected result transaction, key %h", m_tdata[37:6]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[5:0] !== want.rank)
                    report_mismatch("rank", m_tdata[5:0], want.rank);
                if (m_tdata[37:6] !== want.top_key)
                    report_mismatch("top_key", m_tdata[37:6], want.top_key);
                if (m_tuser !== want.key_valid)
                    report_mismatch("key_valid", m_tuser, want.key_valid);
                if (m_tlast !== want.last)
                    report_mismatch("last", m_tlast, want.last);
            end
        end
    end

    // report with nothing stored, then keys at both extremes
    task automatic test_empty_and_extremes();
        write_reg(REG_REPORT_COUNT, 32'd3);
        send_request(REQ_REPORT, 32'h0, 32'h0);
        send_request(REQ_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_UPDATE, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(REQ_UPDATE, 32'hA5A5_5A5A, 32'h0000_0007);
        // weight wrap on an existing key
        send_request(REQ_UPDATE, 32'h0000_0000, 32'h0000_0002);
        send_request(REQ_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // report count zero, saturation, and an ignored index
    task automatic test_report_count_limits();
        send_request(REQ_UPDATE, 32'h1234_5678, 32'd50);
        send_request(REQ_UPDATE, 32'h8765_4321, 32'd40);
        write_reg(REG_REPORT_COUNT, 32'd0);
        send_request(REQ_REPORT, 32'h0, 32'h0);
        write_reg(REG_REPORT_COUNT, 32'd127);
        send_request(REQ_REPORT, 32'h0, 32'h0);
        write_reg(8'd2, 32'd5);
        write_reg(8'hFF, 32'd1);
        write_reg(REG_REPORT_COUNT, 32'd64);
        send_request(REQ_REPORT, 32'h0, 32'h0);
    endtask

    // capacity zero, oversized, and lowered below the fill
    task automatic test_capacity_limits();
        write_reg(REG_CAPACITY, 32'd0);
        write_reg(REG_REPORT_COUNT, 32'd4);
        send_request(REQ_UPDATE, 32'd11, 32'd5);
        send_request(REQ_UPDATE, 32'd12, 32'd3);
        send_request(REQ_REPORT, 32'd0, 32'd0);
        write_reg(REG_CAPACITY, 32'd511);
        for (int i = 0; i < 6; i++) send_request(REQ_UPDATE, 32'd20 + i, 32'd10 + i);
        write_reg(REG_CAPACITY, 32'd2);
        send_request(REQ_UPDATE, 32'd40, 32'd1);
        send_request(REQ_UPDATE, 32'd41, 32'd100);
        send_request(REQ_REPORT, 32'd0, 32'd0);
    endtask

    // receiver holds off while requests keep coming, then sender waits it out
    task automatic test_back_pressure();
        write_reg(REG_CAPACITY, 32'd16);
        write_reg(REG_REPORT_COUNT, 32'd20);
        rx_hold = 1500;
        tx_burst = 1'b1;
        send_request(REQ_REPORT, 32'd0, 32'd0);
        for (int i = 0; i < 4; i++) send_request(REQ_UPDATE, key_pool[i], 32'd9);
        send_request(REQ_REPORT, 32'd0, 32'd0);
        tx_burst = 1'b0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        send_request(REQ_UPDATE, key_pool[5], 32'd3);
    endtask

    // random traffic in phases of different settings
    task automatic test_random_traffic();
        int caps[6] = '{1, 2, 5, 16, 256, 9};
        int roll;
        logic [31:0] key;
        logic [31:0] w;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_CAPACITY, caps[ph]);
            write_reg(REG_REPORT_COUNT, (ph == 4) ? 3 : $urandom_range(1, 12));
            rx_burst = (ph == 2);
            tx_burst = (ph == 3);
            for (int i = 0; i < 14; i++) begin
                roll = $urandom_range(0, 99);
                key = (roll < 80) ? key_pool[$urandom_range(0, 11)] : $urandom;
                w = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100);
                if (roll >= 88) send_request(REQ_REPORT, $urandom, $urandom);
                else send_request(REQ_UPDATE, key, w);
            end
            send_request(REQ_REPORT, 32'd0, 32'd0);
        end
        rx_burst = 1'b0;
        tx_burst = 1'b0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        error_count = 0;
        cycle_count = 0;
        rx_hold     = 0;
        rx_burst    = 1'b0;
        tx_burst    = 1'b0;
        heap_fill   = 0;
        top_n_reg   = RESET_REPORT_COUNT;
        cap_reg     = RESET_CAPACITY;
        for (int i = 1; i <= HEAP_DEPTH; i++) begin
            heap_key[i] = '0;
            heap_cnt[i] = '0;
            heap_val[i] = 1'b0;
        end
        foreach (key_pool[i]) key_pool[i] = $urandom;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_and_extremes();
        test_report_count_limits();
        test_capacity_limits();
        test_back_pressure();
        test_random_traffic();
        drain();

        if (error_count == 0) begin
            $display("space_saving_topk_heap verification clean");
        end else begin
            $display("space_saving_topk_heap verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/ssh_pkg.sv
hw/rtl/ssh_ram.sv
hw/rtl/ssh_core.sv
hw/rtl/space_saving_topk_heap.sv
bench/space_saving_topk_heap_tb.sv
